// ----- hw/rtl/rlmp_pkg.sv -----
// ----------------------------------------------------------------------------
// rlmp_pkg
// Shared types and constants of the radio link message parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rlmp_pkg;

  localparam int LineDepth    = 16;
  localparam int StoreEntries = 11;

  localparam logic [7:0] ChNl   = 8'h0A;
  localparam logic [7:0] ChAt   = 8'h40;
  localparam logic [7:0] ChT    = 8'h54;
  localparam logic [7:0] ChP    = 8'h50;
  localparam logic [7:0] ChC    = 8'h43;
  localparam logic [7:0] ChM    = 8'h4D;
  localparam logic [7:0] ChD    = 8'h44;
  localparam logic [7:0] ChLo   = 8'h6F;
  localparam logic [7:0] ChLn   = 8'h6E;
  localparam logic [7:0] ChA    = 8'h41;
  localparam logic [7:0] ChO    = 8'h4F;
  localparam logic [7:0] ChK    = 8'h4B;
  localparam logic [7:0] ChR    = 8'h52;
  localparam logic [7:0] ChLe   = 8'h65;
  localparam logic [7:0] ChLb   = 8'h62;

  localparam int InWidth  = 8;
  localparam int OutWidth = 72;

  typedef enum logic [2:0] {
    LINK_UNINIT    = 3'b001,
    LINK_CMD       = 3'b010,
    LINK_CONNECTED = 3'b100
  } link_e;

  typedef enum logic [1:0] {
    CODE_UNINIT    = 2'd0,
    CODE_CMD       = 2'd1,
    CODE_CONNECTED = 2'd2
  } link_code_e;

  typedef enum logic [2:0] {
    RESP_ERR    = 3'd0,
    RESP_CMD    = 3'd1,
    RESP_AOK    = 3'd2,
    RESP_REBOOT = 3'd3,
    RESP_CONN   = 3'd4
  } resp_e;

  typedef enum logic [1:0] {
    MSG_OTHER = 2'd0,
    MSG_TASK  = 2'd1,
    MSG_POS   = 2'd2
  } msg_e;

  typedef struct packed {
    link_code_e       link_state;
    logic             line_done;
    resp_e            resp_kind;
    logic             msg_done;
    msg_e             msg_kind;
    logic [1:0][7:0]  task_bytes;
    logic [7:0][7:0]  pos_bytes;
  } item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rlmp_front.sv -----
// ----------------------------------------------------------------------------
// rlmp_front
// Collects received bytes into the line store, tracks the link state and
// classifies closed response lines and messages into queue items.
// ----------------------------------------------------------------------------
`default_nettype none

module rlmp_front #(
  parameter int LINE_DEPTH = rlmp_pkg::LineDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           fire_i,
  input  wire logic [7:0]     byte_i,
  output rlmp_pkg::item_t     item_o
);
  import rlmp_pkg::*;

  localparam int CntW = $clog2(LINE_DEPTH + 1);

  link_e              link_q, link_d;
  logic [CntW-1:0]    count_q, count_d, cnt_inc;
  logic [7:0]         store_q [StoreEntries];
  logic [7:0]         cur     [StoreEntries];
  logic               is_nl, is_at, connected;
  resp_e              resp;
  msg_e               msg;

  always_comb begin
    for (int i = 0; i < StoreEntries; i++) begin
      cur[i] = (count_q == CntW'(i)) ? byte_i : store_q[i];
    end
    cnt_inc   = (count_q < CntW'(LINE_DEPTH)) ? count_q + 1'b1 : count_q;
    is_nl     = (byte_i == ChNl);
    is_at     = (byte_i == ChAt);
    connected = (link_q == LINK_CONNECTED);

    resp = RESP_ERR;
    if (cnt_inc >= CntW'(3)) begin
      if (cur[0] == ChC && cur[1] == ChM && cur[2] == ChD) begin
        resp = RESP_CMD;
      end else if (cur[0] == ChC && cur[1] == ChLo && cur[2] == ChLn) begin
        resp = RESP_CONN;
      end else if (cur[0] == ChA && cur[1] == ChO && cur[2] == ChK) begin
        resp = RESP_AOK;
      end else if (cur[0] == ChR && cur[1] == ChLe && cur[2] == ChLb) begin
        resp = RESP_REBOOT;
      end
    end

    msg = MSG_OTHER;
    if (cur[0] == ChT && cnt_inc >= CntW'(4)) begin
      msg = MSG_TASK;
    end else if (cur[0] == ChP && cnt_inc >= CntW'(11)) begin
      msg = MSG_POS;
    end

    link_d  = link_q;
    count_d = cnt_inc;
    if (!connected && is_nl) begin
      count_d = '0;
      case (link_q)
        LINK_UNINIT: begin
          if (resp == RESP_CMD) link_d = LINK_CMD;
        end
        LINK_CMD: begin
          if (resp == RESP_CONN) link_d = LINK_CONNECTED;
        end
        default: link_d = link_q;
      endcase
    end else if (connected && is_at) begin
      count_d = '0;
    end

    case (link_d)
      LINK_CMD:       item_o.link_state = CODE_CMD;
      LINK_CONNECTED: item_o.link_state = CODE_CONNECTED;
      default:        item_o.link_state = CODE_UNINIT;
    endcase
    item_o.line_done     = !connected && is_nl;
    item_o.resp_kind     = (!connected && is_nl) ? resp : RESP_ERR;
    item_o.msg_done      = connected && is_at;
    item_o.msg_kind      = (connected && is_at) ? msg : MSG_OTHER;
    item_o.task_bytes[0] = cur[1];
    item_o.task_bytes[1] = cur[3];
    for (int i = 0; i < 4; i++) begin
      item_o.pos_bytes[i]     = cur[2 + i];
      item_o.pos_bytes[4 + i] = cur[7 + i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q  <= LINK_UNINIT;
      count_q <= '0;
    end else if (fire_i) begin
      link_q  <= link_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      for (int i = 0; i < StoreEntries; i++) begin
        store_q[i] <= cur[i];
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rlmp_fifo.sv -----
// ----------------------------------------------------------------------------
// rlmp_fifo
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module rlmp_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire rlmp_pkg::item_t item_i,
  output logic                full_o,
  output logic                empty_o,
  input  wire logic           pop_i,
  output rlmp_pkg::item_t     item_o
);
  import rlmp_pkg::*;

  item_t       mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rlmp_back.sv -----
// ----------------------------------------------------------------------------
// rlmp_back
// Applies task and ally position updates and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rlmp_back (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              empty_i,
  input  wire rlmp_pkg::item_t                   item_i,
  output logic                                   pop_o,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [rlmp_pkg::OutWidth-1:0]          m_axis_tdata
);
  import rlmp_pkg::*;

  logic signed [8:0]   task0_q, task1_q, task0_d, task1_d;
  logic signed [18:0]  ax_q, ay_q, ax_d, ay_d;
  logic                valid_q;
  logic [OutWidth-1:0] data_q;

  function automatic logic signed [8:0] digit(input logic [7:0] b);
    return $signed({1'b0, b}) - 9'sd48;
  endfunction

  function automatic logic signed [18:0] four(input logic [3:0][7:0] b);
    logic signed [18:0] d0, d1, d2, d3;
    d0 = 19'(digit(b[0]));
    d1 = 19'(digit(b[1]));
    d2 = 19'(digit(b[2]));
    d3 = 19'(digit(b[3]));
    return d0 * 19'sd1000 + d1 * 19'sd100 + d2 * 19'sd10 + d3;
  endfunction

  assign pop_o         = !empty_i && (!valid_q || m_axis_tready);
  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;

  always_comb begin
    task0_d = task0_q;
    task1_d = task1_q;
    ax_d    = ax_q;
    ay_d    = ay_q;
    case (item_i.msg_kind)
      MSG_TASK: begin
        task0_d = digit(item_i.task_bytes[0]);
        task1_d = digit(item_i.task_bytes[1]);
      end
      MSG_POS: begin
        ax_d = four(item_i.pos_bytes[3:0]);
        ay_d = four(item_i.pos_bytes[7:4]);
      end
      default: begin
        task0_d = task0_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      task0_q <= '0;
      task1_q <= '0;
      ax_q    <= 19'sd16;
      ay_q    <= 19'sd16;
    end else begin
      if (pop_o) begin
        valid_q <= 1'b1;
        task0_q <= task0_d;
        task1_q <= task1_d;
        ax_q    <= ax_d;
        ay_q    <= ay_d;
      end else if (m_axis_tready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= {7'd0, ay_d, ax_d, task1_d, task0_d, item_i.msg_kind, item_i.msg_done,
                 item_i.resp_kind, item_i.line_done, item_i.link_state};
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/radio_link_message_parser.sv -----
// ----------------------------------------------------------------------------
// radio_link_message_parser
// Parses radio module bytes into response line and message results.
//
//   channel  dir  width  content
//   s_axis   in   8      rx_byte
//   m_axis   out  72     link state, line and message flags, task, ally x/y
//
// One byte per cycle while the queue is not full; each result passes the front
// (which classifies), the two-entry queue and the back (which updates the result register).
// Reset clears the link state, byte count and task values and sets the ally
// position to 16.
// A stalled output fills the queue; s_axis_tready drops only when it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module radio_link_message_parser #(
  parameter int LINE_DEPTH = rlmp_pkg::LineDepth
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [7:0] rx_byte
  input  wire logic [rlmp_pkg::InWidth-1:0]      s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [1:0] link_state, [2] line_done, [5:3] response_kind, [6] message_done,
  // [8:7] message_kind, [17:9] task_first, [26:18] task_second,
  // [45:27] ally_x, [64:46] ally_y, [71:65] zero
  output logic [rlmp_pkg::OutWidth-1:0]          m_axis_tdata
);
  import rlmp_pkg::*;

  item_t push_item, head_item;
  logic  fire, full, empty, pop;

  assign s_axis_tready = !full;
  assign fire          = s_axis_tvalid && !full;

  rlmp_front #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (s_axis_tdata),
    .item_o (push_item)
  );

  rlmp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fire),
    .item_i  (push_item),
    .full_o  (full),
    .empty_o (empty),
    .pop_i   (pop),
    .item_o  (head_item)
  );

  rlmp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .item_i        (head_item),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for radio_link_message_parser. A table of directed
// bytes walks the uninitialised state through every response kind and into
// command mode. Random response lines follow, then the link is connected and
// random task, position, short, long and malformed messages are sent. Every
// output beat is compared field by field with a bit-accurate predictor. Both
// stream sides idle and stall at random.
// ----------------------------------------------------------------------------

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rlmp_pkg::*;

  localparam int ProbeCount    = 22;
  localparam int CommandItems  = 300;
  localparam int RandomItems   = 850;
  localparam int QuietLimit    = 2000;
  localparam logic [7:0] ChZero = 8'h30;

  typedef struct packed {
    logic signed [18:0] ally_y;
    logic signed [18:0] ally_x;
    logic signed [8:0]  task_second;
    logic signed [8:0]  task_first;
    msg_e               msg_kind;
    logic               msg_done;
    resp_e              resp_kind;
    logic               line_done;
    link_code_e         link_state;
  } parse_result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       typed;
    link_code_e link;
    logic       line_done;
    resp_e      resp;
  } probe_t;

  localparam probe_t Probes [ProbeCount] = '{
    '{8'h00, 1'b1, CODE_UNINIT, 1'b0, RESP_ERR},
    '{8'hFF, 1'b1, CODE_UNINIT, 1'b0, RESP_ERR},
    '{ChNl,  1'b1, CODE_UNINIT, 1'b1, RESP_ERR},
    '{ChNl,  1'b1, CODE_UNINIT, 1'b1, RESP_ERR},
    '{ChA,   1'b0, CODE_UNINIT, 1'b0, RESP_ERR},
    '{ChO,   1'b0, CODE_UNINIT, 1'b0, RESP_ERR},
    '{ChK,   1'b0, CODE_UNINIT, 1'b0, RESP_ERR},
    '{ChNl,  1'b1, CODE_UNINIT, 1'b1, RESP_AOK},
    '{ChR,   1'b0, CODE_UNINIT, 1'b0, RESP_ERR},
    '{ChLe,  1'b0, CODE_UNINIT, 1'b0, RESP_ERR},
    '{ChLb,  1'b0, CODE_UNINIT, 1'b0, RESP_ERR},
    '{ChNl,  1'b1, CODE_UNINIT, 1'b1, RESP_REBOOT},
    '{ChC,   1'b0, CODE_UNINIT, 1'b0, RESP_ERR},
    '{ChLo,  1'b0, CODE_UNINIT, 1'b0, RESP_ERR},
    '{ChLn,  1'b0, CODE_UNINIT, 1'b0, RESP_ERR},
    '{ChNl,  1'b1, CODE_UNINIT, 1'b1, RESP_CONN},
    '{ChC,   1'b0, CODE_UNINIT, 1'b0, RESP_ERR},
    '{ChM,   1'b0, CODE_UNINIT, 1'b0, RESP_ERR},
    '{ChD,   1'b0, CODE_UNINIT, 1'b0, RESP_ERR},
    '{ChNl,  1'b1, CODE_CMD,    1'b1, RESP_CMD},
    '{ChAt,  1'b0, CODE_CMD,    1'b0, RESP_ERR},
    '{ChNl,  1'b1, CODE_CMD,    1'b1, RESP_ERR}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;

  link_code_e         link_q = CODE_UNINIT;
  logic [7:0]         line_buf [LineDepth];
  int                 fill = 0;
  logic signed [8:0]  task_q [2] = '{9'sd0, 9'sd0};
  logic signed [18:0] ally_x_q = 19'sd16;
  logic signed [18:0] ally_y_q = 19'sd16;

  parse_result_t expected_q [$];
  parse_result_t want_r;
  parse_result_t got_r;
  int            errors = 0;
  int            sent = 0;
  int            calm_left = 0;
  int            quiet = 0;
  bit            draining = 1'b0;

  radio_link_message_parser i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic int digit_at(input int idx);
    return int'(line_buf[idx]) - int'(ChZero);
  endfunction

  function automatic int four_digits(input int first);
    return digit_at(first) * 1000 + digit_at(first + 1) * 100 +
           digit_at(first + 2) * 10 + digit_at(first + 3);
  endfunction

  function automatic parse_result_t predict_byte(input logic [7:0] b);
    parse_result_t r;
    r = '0;
    if (fill < LineDepth) begin
      line_buf[fill] = b;
      fill++;
    end
    if (link_q != CODE_CONNECTED) begin
      if (b == ChNl) begin
        r.line_done = 1'b1;
        r.resp_kind = RESP_ERR;
        if (fill >= 3) begin
          if (line_buf[0] == ChC && line_buf[1] == ChM && line_buf[2] == ChD) begin
            r.resp_kind = RESP_CMD;
          end else if (line_buf[0] == ChC && line_buf[1] == ChLo &&
                       line_buf[2] == ChLn) begin
            r.resp_kind = RESP_CONN;
          end else if (line_buf[0] == ChA && line_buf[1] == ChO &&
                       line_buf[2] == ChK) begin
            r.resp_kind = RESP_AOK;
          end else if (line_buf[0] == ChR && line_buf[1] == ChLe &&
                       line_buf[2] == ChLb) begin
            r.resp_kind = RESP_REBOOT;
          end
        end
        if (link_q == CODE_UNINIT) begin
          if (r.resp_kind == RESP_CMD) link_q = CODE_CMD;
        end else if (r.resp_kind == RESP_CONN) begin
          link_q = CODE_CONNECTED;
        end
        fill = 0;
      end
    end else if (b == ChAt) begin
      r.msg_done = 1'b1;
      r.msg_kind = MSG_OTHER;
      if (fill >= 4 && line_buf[0] == ChT) begin
        task_q[0] = 9'(digit_at(1));
        task_q[1] = 9'(digit_at(3));
        r.msg_kind = MSG_TASK;
      end else if (fill >= 11 && line_buf[0] == ChP) begin
        ally_x_q = 19'(four_digits(2));
        ally_y_q = 19'(four_digits(7));
        r.msg_kind = MSG_POS;
      end
      fill = 0;
    end
    r.link_state  = link_q;
    r.task_first  = task_q[0];
    r.task_second = task_q[1];
    r.ally_x      = ally_x_q;
    r.ally_y      = ally_y_q;
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] any_but(input logic [7:0] stop);
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == stop);
    return v;
  endfunction

  function automatic logic [7:0] field_byte();
    if ($urandom_range(0, 4) != 0) return ChZero + 8'($urandom_range(0, 9));
    return any_but(ChAt);
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      gap = gap_len();
      if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(20, 80);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(predict_byte(b));
    sent++;
  endtask

  task automatic send_tail(input int n, input logic [7:0] stop);
    repeat (n) send_byte(any_but(stop));
  endtask

  initial begin
    m_axis_tready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      if (!draining) begin
        m_axis_tready <= 1'b0;
        repeat (1 + gap_len()) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual %h", $time, m_axis_tdata);
      end else begin
        want_r = expected_q.pop_front();
        got_r  = m_axis_tdata[64:0];
        check_field("link_state", int'(want_r.link_state), int'(got_r.link_state));
        check_field("line_done", int'(want_r.line_done), int'(got_r.line_done));
        check_field("response_kind", int'(want_r.resp_kind), int'(got_r.resp_kind));
        check_field("message_done", int'(want_r.msg_done), int'(got_r.msg_done));
        check_field("message_kind", int'(want_r.msg_kind), int'(got_r.msg_kind));
        check_field("task_first", int'(want_r.task_first), int'(got_r.task_first));
        check_field("task_second", int'(want_r.task_second), int'(got_r.task_second));
        check_field("ally_x", int'(want_r.ally_x), int'(got_r.ally_x));
        check_field("ally_y", int'(want_r.ally_y), int'(got_r.ally_y));
        check_field("pad", 0, int'(m_axis_tdata[71:65]));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QuietLimit) begin
      $display("%0t: no beat for %0d cycles", $time, quiet);
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    int pick;
    int tail;
    logic [7:0] lead;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < ProbeCount; i++) begin
      send_byte(Probes[i].data);
      if (Probes[i].typed) begin
        expected_q[$].link_state = Probes[i].link;
        expected_q[$].line_done  = Probes[i].line_done;
        expected_q[$].resp_kind  = Probes[i].resp;
        expected_q[$].msg_done   = 1'b0;
        expected_q[$].msg_kind   = MSG_OTHER;
      end
    end

    // command mode: response lines of every kind but Connected
    while (sent < ProbeCount + CommandItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        tail = ($urandom_range(0, 9) > 7) ? $urandom_range(10, 22) : $urandom_range(0, 6);
        case ($urandom_range(0, 5))
          0: begin send_byte(ChA); send_byte(ChO); send_byte(ChK); end
          1: begin send_byte(ChR); send_byte(ChLe); send_byte(ChLb); end
          2: begin send_byte(ChC); send_byte(ChM); send_byte(ChD); end
          3: send_tail(3, ChNl);
          4: begin send_tail($urandom_range(0, 2), ChNl); tail = 0; end
          default: begin send_byte(ChC); send_tail(2, ChNl); end
        endcase
        send_tail(tail, ChNl);
        send_byte(ChNl);
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end
    end

    send_byte(ChNl);
    send_byte(ChC);
    send_byte(ChLo);
    send_byte(ChLn);
    send_tail($urandom_range(0, 20), ChNl);
    send_byte(ChNl);

    // connected: messages closed by the at sign
    while (sent < ProbeCount + RandomItems) begin
      pick = $urandom_range(0, 99);
      tail = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 3);
      if (pick < 35) begin
        send_byte(ChT);
        send_byte(field_byte());
        send_byte(any_but(ChAt));
        send_byte(field_byte());
        send_tail(tail, ChAt);
        send_byte(ChAt);
      end else if (pick < 65) begin
        send_byte(ChP);
        send_byte(any_but(ChAt));
        repeat (4) send_byte(field_byte());
        send_byte(any_but(ChAt));
        repeat (4) send_byte(field_byte());
        send_tail(tail, ChAt);
        send_byte(ChAt);
      end else if (pick < 75) begin
        if ($urandom_range(0, 1) != 0) begin
          send_byte(ChT);
          send_tail($urandom_range(0, 2), ChAt);
        end else begin
          send_byte(ChP);
          send_tail($urandom_range(0, 9), ChAt);
        end
        send_byte(ChAt);
      end else if (pick < 85) begin
        case ($urandom_range(0, 2))
          0: lead = ChT;
          1: lead = ChP;
          default: lead = any_but(ChAt);
        endcase
        send_byte(lead);
        send_tail($urandom_range(14, 22), ChAt);
        send_byte(ChAt);
      end else if (pick < 92) begin
        send_tail($urandom_range(0, 5), ChAt);
        send_byte(ChAt);
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      end
    end

    s_axis_tvalid <= 1'b0;
    wait (expected_q.size() == 0);
    draining = 1'b1;
    repeat (80) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/rlmp_pkg.sv
hw/rtl/rlmp_front.sv
hw/rtl/rlmp_fifo.sv
hw/rtl/rlmp_back.sv
hw/rtl/radio_link_message_parser.sv
bench/tb.sv
